### rtl/core/msv_pkg.sv
// Shared types and constants of the sparse matrix-vector unit.
// No dependencies; every other file of the block but msv_ram imports it.
package msv_pkg;

	localparam int KIND_W   = 2;
	localparam int ADDR_W   = 10;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 11;
	localparam int STATUS_W = 2;
	localparam int ROWS_W   = 9;

	localparam int ENTRY_W  = VALUE_W + INDEX_W;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int ACC_W    = 76;
	localparam int FRAC_W   = 24;

	localparam logic [KIND_W-1:0] KIND_LOAD_ENTRY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_VECTOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPUTE     = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ROW_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_COL_ERR = 2'd3;

	localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd1;

	localparam logic signed [ACC_W-1:0]   ROUND_BIAS = ACC_W'(64'd8388608);
	localparam logic signed [VALUE_W-1:0] SAT_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] SAT_MIN    = 32'sh8000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIAG,
		S_PTR,
		S_WALK,
		S_ROUND,
		S_SAT,
		S_FIN
	} state_t;

endpackage

### rtl/core/msv_cfg_if.sv
// Configuration write channel: row count.
// Depends on msv_pkg.
interface msv_cfg_if import msv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROWS_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/msv_req_if.sv
// Request channel: load and compute items.
// Depends on msv_pkg.
interface msv_req_if import msv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [ADDR_W-1:0]         address;
	logic signed [VALUE_W-1:0] value;
	logic [INDEX_W-1:0]        index;

	modport source (output valid, output kind, output address, output value, output index,
		input ready);
	modport sink (input valid, input kind, input address, input value, input index,
		output ready);
endinterface

### rtl/core/msv_rsp_if.sv
// Response channel: row result and status.
// Depends on msv_pkg.
interface msv_rsp_if import msv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] row_result;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output row_result, output status, input ready);
	modport sink (input valid, input row_result, input status, output ready);
endinterface

### rtl/core/msr_sparse_matvec.sv
// Top level of the sparse matrix-vector unit: sequencer, walk pipeline, shared multiplier.
// Depends on msv_pkg, msv_cfg_if, msv_req_if, msv_rsp_if and msv_ram.
//
//   channel | dir | payload                          | transfer when
//   cfg     | in  | data (row count)                 | cfg.valid & cfg.ready
//   req     | in  | kind, address, value, index      | req.valid & req.ready
//   rsp     | out | row_result, status               | rsp.valid & rsp.ready
//
// The off-diagonal entries of a row stream one per cycle through the single
// read port of the entry RAM feeding one shared 32x32 multiplier.
// req.ready is high only while the sequencer is idle; cfg.ready is always high.
// A result waiting on rsp holds the sequencer in its final state.
// Reset clears control state only; the RAMs are not cleared.
module msr_sparse_matvec import msv_pkg::*; #(
	parameter int ENTRY_DEPTH  = 1024,
	parameter int VECTOR_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	msv_cfg_if.sink     cfg,
	msv_req_if.sink     req,
	msv_rsp_if.source   rsp
);

	localparam int EAW  = $clog2(ENTRY_DEPTH);
	localparam int VAW  = $clog2(VECTOR_DEPTH);
	localparam int NCAP = (VECTOR_DEPTH < ENTRY_DEPTH - 1) ? VECTOR_DEPTH : ENTRY_DEPTH - 1;

	state_t state_q, state_nxt;

	logic [ROWS_W-1:0]         row_count_q;
	logic [ROWS_W-1:0]         n_eff;
	logic                      req_xfer;
	logic                      row_ok;
	logic                      issue;
	logic                      pipe_busy;

	logic [ADDR_W-1:0]         addr_q;
	logic [INDEX_W-1:0]        k_q;
	logic [INDEX_W-1:0]        end_q;
	logic                      bad_q;

	logic                      ent_we;
	logic [EAW-1:0]            ent_raddr;
	logic [ENTRY_W-1:0]        ent_rdata;
	logic                      vec_we;
	logic [VAW-1:0]            vec_raddr;
	logic signed [VALUE_W-1:0] vec_rdata;

	logic [INDEX_W-1:0]        rd_index;
	logic signed [VALUE_W-1:0] rd_value;
	logic [INDEX_W-1:0]        rd_index_clamp;
	logic                      col_ok;

	logic                      rd1_s1;
	logic                      rd2_s2;
	logic signed [VALUE_W-1:0] val_s2;
	logic                      mul_s3;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [ACC_W-1:0]   shifted;
	logic                      fits;

	logic signed [VALUE_W-1:0] res_q;
	logic [STATUS_W-1:0]       stat_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_result_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic                      out_free;

	assign n_eff = (32'(row_count_q) > NCAP) ? ROWS_W'(NCAP) : row_count_q;
	assign req_xfer = req.valid && req.ready;
	assign row_ok = req.address < {1'b0, n_eff};
	assign out_free = !out_valid_q || rsp.ready;

	assign rd_value = ent_rdata[VALUE_W-1:0];
	assign rd_index = ent_rdata[ENTRY_W-1:VALUE_W];
	assign rd_index_clamp = (32'(rd_index) > ENTRY_DEPTH) ? INDEX_W'(ENTRY_DEPTH) : rd_index;
	assign col_ok = rd_index < {2'b00, n_eff};
	assign pipe_busy = rd1_s1 || rd2_s2 || mul_s3;

	assign shifted = acc_q >>> FRAC_W;
	assign fits = (&shifted[ACC_W-1:VALUE_W-1]) || !(|shifted[ACC_W-1:VALUE_W-1]);

	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.row_result = out_result_q;
	assign rsp.status = out_status_q;

	msv_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (EAW'(req.address)),
		.wdata ({req.index, req.value}),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	msv_ram #(.WIDTH(VALUE_W), .DEPTH(VECTOR_DEPTH)) u_vector_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (VAW'(req.address)),
		.wdata (req.value),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					state_nxt = (req.kind == KIND_COMPUTE && row_ok) ? S_DIAG : S_FIN;
				end
			end
			S_DIAG:  state_nxt = S_PTR;
			S_PTR:   state_nxt = S_WALK;
			S_WALK: begin
				if (!issue && !pipe_busy) begin
					state_nxt = S_ROUND;
				end
			end
			S_ROUND: state_nxt = S_SAT;
			S_SAT:   state_nxt = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		issue = (state_q == S_WALK) && (k_q < end_q);
		ent_we = req_xfer && req.kind == KIND_LOAD_ENTRY && 32'(req.address) < ENTRY_DEPTH;
		vec_we = req_xfer && req.kind == KIND_LOAD_VECTOR && 32'(req.address) < VECTOR_DEPTH;
		unique case (state_q)
			S_IDLE:  ent_raddr = EAW'(req.address);
			S_DIAG:  ent_raddr = EAW'({1'b0, addr_q} + 11'd1);
			default: ent_raddr = EAW'(k_q);
		endcase
		vec_raddr = (state_q == S_DIAG) ? VAW'(addr_q) : VAW'(rd_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_count_q <= ROWS_RESET;
			rd1_s1 <= 1'b0;
			rd2_s2 <= 1'b0;
			mul_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg.valid && cfg.ready) begin
				row_count_q <= cfg.data;
			end
			rd1_s1 <= issue;
			rd2_s2 <= (state_q == S_DIAG) || (rd1_s1 && col_ok);
			mul_s3 <= rd2_s2;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_xfer) begin
			addr_q <= req.address;
			bad_q <= 1'b0;
			acc_q <= '0;
			res_q <= '0;
			stat_q <= (req.kind == KIND_COMPUTE && !row_ok) ? STATUS_ROW_ERR : STATUS_OK;
		end else if (state_q == S_ROUND) begin
			acc_q <= acc_q + ROUND_BIAS;
		end else if (mul_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end

		if (state_q == S_DIAG) begin
			k_q <= rd_index_clamp;
			val_s2 <= rd_value;
		end else if (rd1_s1) begin
			val_s2 <= rd_value;
		end

		if (state_q == S_PTR) begin
			end_q <= rd_index_clamp;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
		end

		if (rd1_s1 && !col_ok) begin
			bad_q <= 1'b1;
		end

		prod_s3 <= val_s2 * vec_rdata;

		if (state_q == S_SAT) begin
			priority if (bad_q) begin
				res_q <= '0;
				stat_q <= STATUS_COL_ERR;
			end else if (!fits) begin
				res_q <= shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
				stat_q <= STATUS_SAT;
			end else begin
				res_q <= shifted[VALUE_W-1:0];
				stat_q <= STATUS_OK;
			end
		end

		if (state_q == S_FIN && out_free) begin
			out_result_q <= res_q;
			out_status_q <= stat_q;
		end
	end

endmodule

### rtl/core/msv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/msv_checker.sv
// Port-level checks of the sparse matrix-vector unit, bound to its top level.
// Depends on msv_pkg and msr_sparse_matvec.
module msv_checker import msv_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic signed [VALUE_W-1:0] rsp_row_result,
	input logic [STATUS_W-1:0]       rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_result) && $stable(rsp_status))
		else $error("response changed while stalled");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous item in flight");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_ROW_ERR || rsp_status == STATUS_COL_ERR)
		|-> rsp_row_result == '0)
		else $error("flagged row carries nonzero result");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_SAT
		|-> rsp_row_result == SAT_MAX || rsp_row_result == SAT_MIN)
		else $error("saturated result not clamped");

endmodule

bind msr_sparse_matvec msv_checker u_msv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_row_result (rsp.row_result),
	.rsp_status     (rsp.status)
);
